### rtl/sfr_pkg.sv
// ============================================================================
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ============================================================================
package sfr_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIND_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REPL,
        S_FLUSH,
        S_CLOSE
    } sfr_state_t;

    // common controls broadcast along the cell chain
    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

### rtl/sfr_cell.sv
// ============================================================================
// sfr_cell
// One held-byte slot: clears, loads a new byte, takes its neighbor's byte on a
// shift, and compares its byte with the matching pattern byte.
// ============================================================================
module sfr_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sfr_pkg::cell_ctrl_t ctrl,
    input  logic              load_sel,
    input  logic [7:0]        din,
    input  logic [7:0]        nbr,
    input  logic [7:0]        pat,
    output logic [7:0]        q,
    output logic              match
);
    import sfr_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_next = nbr;
        end
        else if (ctrl.load && load_sel)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q     = byte_reg;
    assign match = (byte_reg == pat);

endmodule

### rtl/stream_find_replace_top.sv
// ============================================================================
// stream_find_replace_top
// Streaming find-and-replace over a byte stream with a capacity check.
// ============================================================================
// Flow: an accepted byte is appended in S_IDLE and checked in S_CHECK; a released
//   literal, replacement byte or closing result is loaded into the shared
//   output register, which holds it while the output stalls.
// Input: not ready again until the item is checked, its released bytes are emitted
//   or dropped, any replacement is loaded, and an end of string is closed.
// Reset: asynchronous, active low; clears held bytes, counters, flags and
//   loads the register defaults.
module stream_find_replace_top #(
    parameter int MAX_FIND_LEN    = 8,
    parameter int MAX_REPLACE_LEN = 8,
    parameter int COUNT_BITS      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_stream
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [0] out_byte_present, [1] overflow
    output logic        m_axis_tlast    // last_of_stream
);
    import sfr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FIND_LEN + 1);
    localparam int RIDX_W = $clog2(MAX_REPLACE_LEN + 1);
    localparam int CMP_W  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    // configuration registers
    logic [63:0] find_pattern_reg;
    logic [3:0]  find_length_reg;
    logic [63:0] replace_pattern_reg;
    logic [3:0]  replace_length_reg;
    logic [15:0] output_capacity_reg;

    // control state
    sfr_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [COUNT_BITS-1:0]  emitted_reg, emitted_next;
    logic                   ovf_reg, ovf_next;
    logic                   end_reg, end_next;
    logic [RIDX_W-1:0]      rep_idx_reg, rep_idx_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_present_reg, out_present_next;
    logic       out_last_reg, out_last_next;
    logic       out_ovf_reg, out_ovf_next;

    // cell chain
    cell_ctrl_t              cell_ctrl;
    logic [7:0]              cell_q   [MAX_FIND_LEN];
    logic [MAX_FIND_LEN-1:0] cell_match;
    logic [MAX_FIND_LEN-1:0] cell_sel;
    logic [MAX_FIND_LEN-1:0] in_count;

    logic [3:0] flen;
    logic [3:0] rlen;
    logic [3:0] count_ext;
    logic       accept;
    logic       out_free;
    logic       prefix;
    logic       release_req;
    logic       lit_ok;
    logic       lit_over;
    logic       stall;
    logic       repl_ok;
    logic       repl_over;
    logic       out_load;
    logic [CMP_W-1:0] emitted_ext;
    logic [CMP_W-1:0] cap_ext;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FIND_LEN; gi++)
        begin : g_cell
            logic [7:0] nbr_byte;
            if (gi == MAX_FIND_LEN - 1)
            begin : g_end
                assign nbr_byte = 8'd0;
            end
            else
            begin : g_mid
                assign nbr_byte = cell_q[gi+1];
            end
            assign cell_sel[gi] = (count_reg == CNT_W'(gi));
            assign in_count[gi] = (CNT_W'(gi) < count_reg);
            sfr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .load_sel (cell_sel[gi]),
                .din      (s_axis_tdata),
                .nbr      (nbr_byte),
                .pat      (find_pattern_reg[8*gi +: 8]),
                .q        (cell_q[gi]),
                .match    (cell_match[gi])
            );
        end
    endgenerate

    assign flen = (find_length_reg > 4'(MAX_FIND_LEN)) ? 4'(MAX_FIND_LEN) : find_length_reg;
    assign rlen = (replace_length_reg > 4'(MAX_REPLACE_LEN)) ? 4'(MAX_REPLACE_LEN)
                                                             : replace_length_reg;
    assign count_ext   = 4'(count_reg);
    assign emitted_ext = CMP_W'(emitted_reg);
    assign cap_ext     = CMP_W'(output_capacity_reg);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // held bytes must be a prefix of the pattern
    assign prefix      = (count_ext <= flen) && ((cell_match | ~in_count) == '1);
    assign release_req = (count_reg != '0) &&
                         ((state_reg == S_FLUSH) || !prefix);
    assign lit_ok      = !ovf_reg && (emitted_ext + CMP_W'(2) <= cap_ext);
    assign lit_over    = !ovf_reg && !(emitted_ext + CMP_W'(2) <= cap_ext);
    assign stall       = release_req && lit_ok && !out_free;
    assign repl_ok     = !ovf_reg && (emitted_ext + CMP_W'(rlen) + CMP_W'(1) <= cap_ext);
    assign repl_over   = !ovf_reg && !(emitted_ext + CMP_W'(rlen) + CMP_W'(1) <= cap_ext);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (flen == 4'd0)
                    begin
                        state_next = s_axis_tlast ? S_FLUSH : S_IDLE;
                    end
                    else if (s_axis_tuser)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_CHECK:
            begin
                if (!release_req)
                begin
                    if (count_ext == flen && repl_ok && rlen != 4'd0)
                    begin
                        state_next = S_REPL;
                    end
                    else
                    begin
                        state_next = end_reg ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_REPL:
            begin
                if (out_free && 4'(rep_idx_reg) + 4'd1 == rlen)
                begin
                    state_next = end_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cell_ctrl        = '0;
        count_next       = count_reg;
        emitted_next     = emitted_reg;
        ovf_next         = ovf_reg;
        end_next         = end_reg;
        rep_idx_next     = rep_idx_reg;
        out_load         = 1'b0;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        out_ovf_next     = out_ovf_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    end_next = s_axis_tlast;
                    if (flen == 4'd0)
                    begin
                        if (s_axis_tuser || s_axis_tlast)
                        begin
                            cell_ctrl.clear = 1'b1;
                            count_next      = '0;
                            ovf_next        = 1'b1;
                        end
                    end
                    else if (s_axis_tuser)
                    begin
                        cell_ctrl.load = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
            end
            S_CHECK, S_FLUSH:
            begin
                if (release_req)
                begin
                    if (!stall)
                    begin
                        // release the oldest held byte as a literal
                        cell_ctrl.shift = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                        if (lit_over)
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (lit_ok)
                        begin
                            out_load         = 1'b1;
                            out_byte_next    = cell_q[0];
                            out_present_next = 1'b1;
                            out_last_next    = 1'b0;
                            out_ovf_next     = 1'b0;
                            emitted_next     = emitted_reg + COUNT_BITS'(1);
                        end
                    end
                end
                else if (state_reg == S_CHECK && count_ext == flen)
                begin
                    cell_ctrl.clear = 1'b1;
                    count_next      = '0;
                    rep_idx_next    = '0;
                    if (repl_over)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_REPL:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = replace_pattern_reg[8*rep_idx_reg +: 8];
                    out_present_next = 1'b1;
                    out_last_next    = 1'b0;
                    out_ovf_next     = 1'b0;
                    emitted_next     = emitted_reg + COUNT_BITS'(1);
                    rep_idx_next     = rep_idx_reg + RIDX_W'(1);
                end
            end
            S_CLOSE:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = 8'd0;
                    out_present_next = 1'b0;
                    out_last_next    = 1'b1;
                    out_ovf_next     = ovf_reg || (emitted_ext + CMP_W'(1) > cap_ext);
                    cell_ctrl.clear  = 1'b1;
                    count_next       = '0;
                    emitted_next     = '0;
                    ovf_next         = 1'b0;
                    end_next         = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            emitted_reg   <= '0;
            ovf_reg       <= 1'b0;
            end_reg       <= 1'b0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emitted_reg   <= emitted_next;
            ovf_reg       <= ovf_next;
            end_reg       <= end_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
        out_ovf_reg     <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pattern_reg    <= 64'd0;
            find_length_reg     <= 4'd1;
            replace_pattern_reg <= 64'd0;
            replace_length_reg  <= 4'd0;
            output_capacity_reg <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIND_PATTERN:    find_pattern_reg    <= cfg_data;
                REG_FIND_LENGTH:     find_length_reg     <= cfg_data[3:0];
                REG_REPLACE_PATTERN: replace_pattern_reg <= cfg_data;
                REG_REPLACE_LENGTH:  replace_length_reg  <= cfg_data[3:0];
                REG_OUTPUT_CAPACITY: output_capacity_reg <= cfg_data[15:0];
                default:             find_length_reg     <= find_length_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_present_reg};
    assign m_axis_tlast  = out_last_reg;

    // held bytes never outgrow the cell chain
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FIND_LEN))
        else $error("held count beyond cell chain");

    // overflow stays set until the string closes
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg && (state_reg != S_CLOSE) |=> ovf_reg)
        else $error("overflow flag dropped mid-string");

    // no byte result is produced once overflow is seen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_present_next |-> !ovf_reg)
        else $error("byte emitted after overflow");

    // a result is never overwritten while it waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !out_load)
        else $error("pending result overwritten");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking test of stream_find_replace_top. Byte streams with frequent
// pattern fragments are sent under bursty input and a stalling output, and
// every output transaction is compared with a built-in prediction of the
// find-and-replace, capacity and overflow behavior.
// ============================================================================

typedef struct packed {
    logic [7:0] out_byte;
    logic       present;
    logic       last;
    logic       ovf;
} text_res_t;

class replace_scoreboard;
    logic [63:0] find_pat;
    logic [63:0] repl_pat;
    int          find_len;
    int          repl_len;
    int          capacity;

    logic [7:0]  held [8];
    int          held_n;
    int          emitted;
    bit          ovf_seen;
    int          step_n;

    text_res_t   pending_q [$];
    int          errors;
    int          n_checked;

    function void init();
        find_pat = '0;
        find_len = 1;
        repl_pat = '0;
        repl_len = 0;
        capacity = 65535;
        errors = 0;
        n_checked = 0;
        clear_string();
    endfunction

    function void clear_string();
        foreach (held[i]) held[i] = 8'h00;
        held_n = 0;
        emitted = 0;
        ovf_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            sfr_pkg::REG_FIND_PATTERN:    find_pat = val;
            sfr_pkg::REG_FIND_LENGTH:     find_len = int'(val[3:0]);
            sfr_pkg::REG_REPLACE_PATTERN: repl_pat = val;
            sfr_pkg::REG_REPLACE_LENGTH:  repl_len = int'(val[3:0]);
            sfr_pkg::REG_OUTPUT_CAPACITY: capacity = int'(val[15:0]);
            default: ;
        endcase
    endfunction

    function void push(logic [7:0] b, logic p, logic l, logic o);
        text_res_t r;
        if (step_n >= 16) return;
        r.out_byte = b;
        r.present = p;
        r.last = l;
        r.ovf = o;
        pending_q.push_back(r);
        step_n++;
    endfunction

    function void emit_literal(logic [7:0] b);
        if (ovf_seen) return;
        if (emitted + 2 > capacity) begin
            ovf_seen = 1;
            return;
        end
        push(b, 1'b1, 1'b0, 1'b0);
        emitted = (emitted + 1) & 16'hFFFF;
    endfunction

    function void emit_replacement();
        int rl;
        rl = (repl_len > 8) ? 8 : repl_len;
        if (ovf_seen) return;
        if (emitted + rl + 1 > capacity) begin
            ovf_seen = 1;
            return;
        end
        for (int i = 0; i < rl; i++) begin
            push(repl_pat[8*i +: 8], 1'b1, 1'b0, 1'b0);
            emitted = (emitted + 1) & 16'hFFFF;
        end
    endfunction

    function void release_oldest();
        if (held_n == 0) return;
        emit_literal(held[0]);
        for (int i = 1; i < held_n; i++) held[i-1] = held[i];
        held_n--;
        held[held_n] = 8'h00;
    endfunction

    function bit held_matches_prefix(int fl);
        if (held_n > fl) return 0;
        for (int i = 0; i < held_n; i++)
            if (held[i] != find_pat[8*i +: 8]) return 0;
        return 1;
    endfunction

    // predict the results of one accepted input transaction
    function void note_input(logic [7:0] b, logic p, logic e);
        int fl;
        fl = (find_len > 8) ? 8 : find_len;
        step_n = 0;
        if (fl == 0) begin
            if (p || e) begin
                foreach (held[i]) held[i] = 8'h00;
                held_n = 0;
                ovf_seen = 1;
            end
        end else if (p) begin
            while (held_n >= 8) release_oldest();
            held[held_n] = b;
            held_n++;
            while (held_n > 0 && !held_matches_prefix(fl)) release_oldest();
            if (held_n == fl) begin
                foreach (held[i]) held[i] = 8'h00;
                held_n = 0;
                emit_replacement();
            end
        end
        if (e) begin
            while (held_n > 0) release_oldest();
            if (emitted + 1 > capacity) ovf_seen = 1;
            push(8'h00, 1'b0, 1'b1, ovf_seen);
            clear_string();
        end
    endfunction

    function void check_result(logic [7:0] b, logic p, logic l, logic o);
        text_res_t x;
        n_checked++;
        if (pending_q.size() == 0) begin
            $error("unexpected output transaction byte=%0h present=%0b last=%0b", b, p, l);
            errors++;
            return;
        end
        x = pending_q.pop_front();
        if (b !== x.out_byte) begin
            $error("out_byte: expected %0h, got %0h", x.out_byte, b);
            errors++;
        end
        if (p !== x.present) begin
            $error("out_byte_present: expected %0b, got %0b", x.present, p);
            errors++;
        end
        if (l !== x.last) begin
            $error("last_of_stream: expected %0b, got %0b", x.last, l);
            errors++;
        end
        if (o !== x.ovf) begin
            $error("overflow: expected %0b, got %0b", x.ovf, o);
            errors++;
        end
    endfunction
endclass

module testbench;
    import sfr_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    replace_scoreboard sb;
    int burst_left;
    int n_items;
    int n_strings;
    int idle_cycles;
    int stall_mode;
    int stall_cnt;
    logic [7:0] alphabet [4];

    stream_find_replace_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: checks each output transaction and periodically picks a new random stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 50 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (stall_cnt % 8) < 5;
            endcase
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL stream_find_replace_top");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(input logic [63:0] fp, input int fl, input logic [63:0] rp,
                             input int rl, input int cap);
        write_reg(REG_FIND_PATTERN, fp);
        write_reg(REG_FIND_LENGTH, 64'(fl));
        write_reg(REG_REPLACE_PATTERN, rp);
        write_reg(REG_REPLACE_LENGTH, 64'(rl));
        write_reg(REG_OUTPUT_CAPACITY, 64'(cap));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= p;
        s_axis_tlast <= e;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(b, p, e);
        if (p || e) n_items++;
        if (e) n_strings++;
    endtask

    // hold until all results are in, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_text(input string txt, input logic end_byte);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b1, (i == txt.len() - 1) && end_byte);
        if (!end_byte) send_item(8'h00, 1'b0, 1'b1);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 6) == 0) return 8'($urandom);
        return alphabet[$urandom_range(0, 3)];
    endfunction

    task automatic random_string(input int fl);
        int len;
        int k;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 14);
        k = 0;
        while (k < len)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            else if ($urandom_range(0, 2) == 0 && fl > 0)
            begin
                // pattern prefix, sometimes whole
                for (int j = 0; j < $urandom_range(1, (fl > 8) ? 8 : fl); j++)
                begin
                    send_item(sb.find_pat[8*j +: 8], 1'b1, 1'b0);
                    k++;
                end
            end
            else
            begin
                send_item(pick_byte(), 1'b1, 1'b0);
                k++;
            end
        end
        if ($urandom_range(0, 1)) send_item(pick_byte(), 1'b1, 1'b1);
        else send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int fl;
        int rl;
        int cap;
        logic [63:0] fp;
        logic [63:0] rp;
        int start;

        sb = new();
        sb.init();
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FIND_PATTERN;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        s_axis_tlast <= 1'b0;
        burst_left = 0;
        n_items = 0;
        n_strings = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: find "ab", replace "XYZ"
        write_all(64'h6261, 2, 64'h5A5958, 3, 65535);
        send_text("aab", 1'b1);
        send_text("ababa", 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // pattern changed while a byte is held
        send_item("a", 1'b1, 1'b0);
        drain();
        write_all(64'h6361, 2, 64'h00, 0, 6);
        send_text("cxacac", 1'b1);
        drain();
        // zero capacity, then an empty pattern
        write_all(64'h61, 1, 64'h5A, 1, 0);
        send_text("b", 1'b1);
        drain();
        write_all(64'h61, 0, 64'h5A, 1, 65535);
        send_text("ab", 1'b1);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
            fl = (ph == 1) ? 0 : (ph == 2) ? 15 : (ph == 3) ? 8 : $urandom_range(1, 4);
            rl = (ph == 4) ? 0 : (ph == 2) ? 15 : (ph == 5) ? 8 : $urandom_range(0, 5);
            cap = (ph == 6) ? 0 : (ph == 7) ? 1 : (ph >= 8 && ph <= 9) ? 65535
                : $urandom_range(2, 30);
            rp = {$urandom, $urandom};
            fp = '0;
            for (int j = 0; j < 8; j++) fp[8*j +: 8] = alphabet[$urandom_range(0, 3)];
            if (ph == 10) fp = '1;
            if (ph == 11) fp = '0;
            if (ph >= 10) alphabet[0] = fp[7:0];
            write_all(fp, fl, rp, rl, cap);
            start = n_items;
            while (n_items - start < 28) random_string(fl);
            drain();
        end

        if (sb.pending_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("Covered %0d input items in %0d strings, %0d results checked,",
                 n_items, n_strings, sb.n_checked);
        $display("over 16 register settings incl. empty/oversized lengths and zero capacity.");
        if (sb.errors == 0)
            $display("PASS stream_find_replace_top");
        else
            $display("FAIL stream_find_replace_top");
        $finish;
    end
endmodule

### filelist.f
rtl/sfr_pkg.sv
rtl/sfr_cell.sv
rtl/stream_find_replace_top.sv
tb/sv/testbench.sv
